/* rtl/core/lzd_pkg.sv */
// Shared types and constants for the plain LZ77 stream decompressor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lzd_pkg;

  localparam int LZD_WINDOW_BYTES = 8192;
  localparam int LZD_WIN_AW       = $clog2(LZD_WINDOW_BYTES);
  localparam int LZD_MAX_BURST    = 64;
  localparam int LZD_QUEUE_DEPTH  = 4;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_CONT = 1'b1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_PENDING = 3'd1,
    ST_LIMIT   = 3'd2,
    ST_END     = 3'd3,
    ST_BADOFF  = 3'd4,
    ST_TRUNC   = 3'd5
  } status_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       run_last;
    status_t    status;
  } out_item_t;

endpackage

/* rtl/core/plain_lz77_stream_decompressor.sv */
// Top level of the plain LZ77 stream decompressor.
// Depends on lzd_pkg, lzd_front, lzd_back and lzd_out_q.
//
//  channel   handshake        payload
//  input     push / full      cmd, in_byte, in_last
//  result    empty / pop      out_valid, out_byte, run_last, status
//  config    cfg_wr_en        cfg_wr_data (output limit)
//
// In the decode engine each compressed byte is first dequeued, then parsed.
// Each copied byte is a history read, then the registered read data is written back
// and queued, so the single-port 8192-byte history is read and written in separate states.
// Four-entry queues on both sides let the ports stall independently of the engine.
// rst is synchronous; the history needs no clearing pass after reset.
`timescale 1ns / 1ps

module plain_lz77_stream_decompressor #(
  parameter int MAX_BURST = lzd_pkg::LZD_MAX_BURST
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        cmd,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        empty,
  input  logic        pop,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic [2:0]  status,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);
  import lzd_pkg::*;

  in_item_t  wr_item;
  in_item_t  eng_in;
  logic      eng_avail;
  logic      eng_take;
  logic      oq_full;
  logic      oq_wr;
  out_item_t oq_in;
  out_item_t oq_out;

  assign wr_item = '{cmd: cmd, in_byte: in_byte, in_last: in_last};

  lzd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .wr_item (wr_item),
    .take    (eng_take),
    .avail   (eng_avail),
    .rd_item (eng_in)
  );

  lzd_back #(
    .MAX_BURST (MAX_BURST)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_avail    (eng_avail),
    .in_item     (eng_in),
    .in_take     (eng_take),
    .out_full    (oq_full),
    .out_push    (oq_wr),
    .out_item    (oq_in)
  );

  lzd_out_q u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr      (oq_wr),
    .full    (oq_full),
    .wr_item (oq_in),
    .pop     (pop),
    .empty   (empty),
    .rd_item (oq_out)
  );

  assign out_valid = oq_out.out_valid;
  assign out_byte  = oq_out.out_byte;
  assign run_last  = oq_out.run_last;
  assign status    = oq_out.status;

endmodule

/* rtl/core/lzd_front.sv */
// Front end: input queue that accepts compressed-stream transactions.
// Depends on lzd_pkg.
`timescale 1ns / 1ps

module lzd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  lzd_pkg::in_item_t  wr_item,
  input  logic               take,
  output logic               avail,
  output lzd_pkg::in_item_t  rd_item
);
  import lzd_pkg::*;

  localparam int AW = $clog2(LZD_QUEUE_DEPTH);

  in_item_t       slots [LZD_QUEUE_DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;
  logic           do_wr;
  logic           do_rd;

  assign full    = (count == (AW+1)'(LZD_QUEUE_DEPTH));
  assign avail   = (count != '0);
  assign do_wr   = push && !full;
  assign do_rd   = take && avail;
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/lzd_out_q.sv */
// Result queue between the decode engine and the output port.
// Depends on lzd_pkg.
`timescale 1ns / 1ps

module lzd_out_q (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  output logic                full,
  input  lzd_pkg::out_item_t  wr_item,
  input  logic                pop,
  output logic                empty,
  output lzd_pkg::out_item_t  rd_item
);
  import lzd_pkg::*;

  localparam int AW = $clog2(LZD_QUEUE_DEPTH);

  out_item_t      slots [LZD_QUEUE_DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;
  logic           do_wr;
  logic           do_rd;

  assign full    = (count == (AW+1)'(LZD_QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = pop && !empty;
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/lzd_back.sv */
// Back end: token parser, history window and match copy sequencer.
// Depends on lzd_pkg.
`timescale 1ns / 1ps

module lzd_back #(
  parameter int MAX_BURST = lzd_pkg::LZD_MAX_BURST
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [31:0]         cfg_wr_data,
  input  logic                in_avail,
  input  lzd_pkg::in_item_t   in_item,
  output logic                in_take,
  input  logic                out_full,
  output logic                out_push,
  output lzd_pkg::out_item_t  out_item
);
  import lzd_pkg::*;

  localparam int BW = $clog2(MAX_BURST + 1);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_RD, S_WR} state_t;

  typedef enum logic [3:0] {
    PH_FLAG0      = 4'd0,
    PH_FLAG1      = 4'd1,
    PH_FLAG2      = 4'd2,
    PH_FLAG3      = 4'd3,
    PH_ITEM       = 4'd4,
    PH_TOK_HI     = 4'd5,
    PH_NIB        = 4'd6,
    PH_EXT8       = 4'd7,
    PH_EXT16_LO   = 4'd8,
    PH_EXT16_HI   = 4'd9,
    PH_INPUT_DONE = 4'd10
  } phase_t;

  state_t                 state;
  in_item_t               cur;
  logic [31:0]            output_limit;
  logic [31:0]            bytes_written;
  logic [31:0]            flag_word;
  logic [5:0]             flags_left;
  phase_t                 phase;
  logic [15:0]            token_value;
  logic [LZD_WIN_AW-1:0]  match_offset;
  logic [16:0]            copy_remaining;
  logic [3:0]             saved_nib;
  logic                   nib_pending;
  status_t                finished;
  logic [BW-1:0]          burst_n;

  logic [7:0]             history [LZD_WINDOW_BYTES];
  logic [7:0]             rd_data;
  logic                   mem_we;
  logic [7:0]             mem_wdata;
  logic [LZD_WIN_AW-1:0]  src_addr;

  // parse results for the current byte
  phase_t                 phase_next;
  logic [31:0]            flag_word_next;
  logic [5:0]             flags_left_next;
  logic [15:0]            token_value_next;
  logic [LZD_WIN_AW-1:0]  match_offset_next;
  logic [3:0]             saved_nib_next;
  logic                   nib_pending_next;
  logic                   p_lit;
  logic                   p_copy;
  logic [16:0]            p_len;
  logic                   use_nib;
  logic [3:0]             nib;
  logic [1:0]             flag_idx;
  logic [5:0]             fl_dec;
  logic [15:0]            tok_hi;

  logic                   act;
  logic                   lim_now;
  logic [31:0]            bw_inc;
  logic                   lim_inc;
  logic                   last_in;
  logic                   bad_off;
  logic [16:0]            rem_dec;
  logic                   burst_end;
  status_t                end_fin;
  logic                   lit_go;

  always_comb begin
    phase_next        = phase;
    flag_word_next    = flag_word;
    flags_left_next   = flags_left;
    token_value_next  = token_value;
    match_offset_next = match_offset;
    saved_nib_next    = saved_nib;
    nib_pending_next  = nib_pending;
    p_lit             = 1'b0;
    p_copy            = 1'b0;
    p_len             = '0;
    use_nib           = 1'b0;
    nib               = '0;
    fl_dec            = flags_left - 6'd1;
    tok_hi            = {cur.in_byte, token_value[7:0]};
    case (phase)
      PH_FLAG1: flag_idx = 2'd1;
      PH_FLAG2: flag_idx = 2'd2;
      PH_FLAG3: flag_idx = 2'd3;
      default:  flag_idx = 2'd0;
    endcase
    case (phase)
      PH_ITEM: begin
        flags_left_next = fl_dec;
        if (!flag_word[fl_dec[4:0]]) begin
          p_lit      = 1'b1;
          phase_next = (fl_dec == '0) ? PH_FLAG0 : PH_ITEM;
        end else begin
          token_value_next = {8'd0, cur.in_byte};
          phase_next       = PH_TOK_HI;
        end
      end
      PH_TOK_HI: begin
        token_value_next  = tok_hi;
        match_offset_next = tok_hi[15:3];
        if (tok_hi[2:0] != 3'd7) begin
          p_copy = 1'b1;
          p_len  = 17'(tok_hi[2:0]) + 17'd3;
        end else if (nib_pending) begin
          nib_pending_next = 1'b0;
          use_nib          = 1'b1;
          nib              = saved_nib;
        end else begin
          phase_next = PH_NIB;
        end
      end
      PH_NIB: begin
        saved_nib_next   = cur.in_byte[7:4];
        nib_pending_next = 1'b1;
        use_nib          = 1'b1;
        nib              = cur.in_byte[3:0];
      end
      PH_EXT8: begin
        if (cur.in_byte != 8'hFF) begin
          p_copy = 1'b1;
          p_len  = 17'(cur.in_byte) + 17'd25;
        end else begin
          phase_next = PH_EXT16_LO;
        end
      end
      PH_EXT16_LO: begin
        token_value_next = {8'd0, cur.in_byte};
        phase_next       = PH_EXT16_HI;
      end
      PH_EXT16_HI: begin
        p_copy = 1'b1;
        p_len  = {1'b0, cur.in_byte, token_value[7:0]} + 17'd3;
      end
      default: begin
        if (flag_idx == 2'd0) begin
          flag_word_next = {24'd0, cur.in_byte};
        end else begin
          flag_word_next = flag_word | ({24'd0, cur.in_byte} << {flag_idx, 3'b000});
        end
        if (flag_idx == 2'd3) begin
          flags_left_next = 6'd32;
          phase_next      = PH_ITEM;
        end else begin
          phase_next = phase_t'({2'b00, flag_idx + 2'd1});
        end
      end
    endcase
    if (use_nib) begin
      if (nib != 4'hF) begin
        p_copy = 1'b1;
        p_len  = 17'(nib) + 17'd10;
      end else begin
        phase_next = PH_EXT8;
      end
    end
    if (p_copy) begin
      phase_next = (flags_left == '0) ? PH_FLAG0 : PH_ITEM;
    end
  end

  assign act       = ((state == S_EXEC) || (state == S_WR)) && !out_full;
  assign lim_now   = (bytes_written >= output_limit);
  assign bw_inc    = bytes_written + 32'd1;
  assign lim_inc   = (bw_inc >= output_limit);
  assign last_in   = (cur.cmd == CMD_PUSH) && cur.in_last;
  assign bad_off   = ({19'd0, match_offset_next} >= bytes_written);
  assign rem_dec   = copy_remaining - 17'd1;
  assign burst_end = (burst_n == BW'(MAX_BURST - 1));
  assign end_fin   = ((phase_next == PH_FLAG0) || (phase_next == PH_ITEM)) ? ST_END : ST_TRUNC;
  assign src_addr  = bytes_written[LZD_WIN_AW-1:0] - match_offset - LZD_WIN_AW'(1);
  assign in_take   = (state == S_IDLE) && in_avail;

  assign lit_go = (state == S_EXEC) && (finished == ST_OK) && !lim_now
                  && (cur.cmd == CMD_PUSH) && (copy_remaining == '0) && p_lit;
  assign mem_we    = act && (lit_go || (state == S_WR));
  assign mem_wdata = (state == S_WR) ? rd_data : cur.in_byte;

  always_comb begin
    out_push = 1'b0;
    out_item = '{out_valid: 1'b0, out_byte: 8'd0, run_last: 1'b1, status: ST_OK};
    case (state)
      S_EXEC: begin
        if (finished != ST_OK) begin
          out_push        = 1'b1;
          out_item.status = finished;
        end else if (lim_now) begin
          out_push        = 1'b1;
          out_item.status = ST_LIMIT;
        end else if (cur.cmd == CMD_CONT) begin
          out_push = 1'b0;
        end else if (copy_remaining != '0) begin
          out_push        = 1'b1;
          out_item.status = ST_PENDING;
        end else if (p_lit) begin
          out_push           = 1'b1;
          out_item.out_valid = 1'b1;
          out_item.out_byte  = cur.in_byte;
          out_item.status    = lim_inc ? ST_LIMIT : (last_in ? ST_END : ST_OK);
        end else if (p_copy) begin
          out_push        = bad_off;
          out_item.status = ST_BADOFF;
        end else if (last_in) begin
          out_push        = 1'b1;
          out_item.status = end_fin;
        end
      end
      S_WR: begin
        out_push           = 1'b1;
        out_item.out_valid = 1'b1;
        out_item.out_byte  = rd_data;
        if (lim_inc) begin
          out_item.status = ST_LIMIT;
        end else if (rem_dec == '0) begin
          out_item.status = (last_in || (phase == PH_INPUT_DONE)) ? ST_END : ST_OK;
        end else if (burst_end) begin
          out_item.status = ST_PENDING;
        end else begin
          out_item.run_last = 1'b0;
        end
      end
      default: out_push = 1'b0;
    endcase
    if (out_full) begin
      out_push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      history[bytes_written[LZD_WIN_AW-1:0]] <= mem_wdata;
    end
    if (state == S_RD) begin
      rd_data <= history[src_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      output_limit   <= '0;
      bytes_written  <= '0;
      flag_word      <= '0;
      flags_left     <= '0;
      phase          <= PH_FLAG0;
      token_value    <= '0;
      match_offset   <= '0;
      copy_remaining <= '0;
      saved_nib      <= '0;
      nib_pending    <= 1'b0;
      finished       <= ST_OK;
      burst_n        <= '0;
    end else begin
      if (cfg_wr_en) begin
        output_limit <= cfg_wr_data;
      end
      case (state)
        S_IDLE: begin
          if (in_avail) begin
            cur   <= in_item;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (!out_full) begin
            state <= S_IDLE;
            if (finished != ST_OK) begin
              state <= S_IDLE;
            end else if (lim_now) begin
              finished       <= ST_LIMIT;
              copy_remaining <= '0;
            end else if (cur.cmd == CMD_CONT) begin
              if (copy_remaining != '0) begin
                burst_n <= '0;
                state   <= S_RD;
              end
            end else if (copy_remaining == '0) begin
              phase        <= phase_next;
              flag_word    <= flag_word_next;
              flags_left   <= flags_left_next;
              token_value  <= token_value_next;
              match_offset <= match_offset_next;
              saved_nib    <= saved_nib_next;
              nib_pending  <= nib_pending_next;
              if (p_lit) begin
                bytes_written <= bw_inc;
                if (lim_inc) begin
                  finished <= ST_LIMIT;
                end else if (last_in) begin
                  finished <= ST_END;
                end
              end else if (p_copy) begin
                if (bad_off) begin
                  finished <= ST_BADOFF;
                end else begin
                  copy_remaining <= p_len;
                  burst_n        <= '0;
                  state          <= S_RD;
                end
              end else if (last_in) begin
                finished <= end_fin;
              end
            end
          end
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          if (!out_full) begin
            bytes_written  <= bw_inc;
            copy_remaining <= rem_dec;
            burst_n        <= burst_n + 1'b1;
            state          <= S_IDLE;
            if (lim_inc) begin
              finished       <= ST_LIMIT;
              copy_remaining <= '0;
            end else if (rem_dec == '0) begin
              if (last_in || (phase == PH_INPUT_DONE)) begin
                finished <= ST_END;
              end
            end else if (burst_end) begin
              if (last_in) begin
                phase <= PH_INPUT_DONE;
              end
            end else begin
              state <= S_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/lzd_checker.sv */
// Port-level checks for the plain LZ77 stream decompressor, bound to the top.
// Depends on lzd_pkg and plain_lz77_stream_decompressor.
`timescale 1ns / 1ps

module lzd_checker (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        cmd,
  input logic [7:0]  in_byte,
  input logic        in_last,
  input logic        empty,
  input logic        pop,
  input logic        out_valid,
  input logic [7:0]  out_byte,
  input logic        run_last,
  input logic [2:0]  status,
  input logic        cfg_wr_en,
  input logic [31:0] cfg_wr_data
);
  import lzd_pkg::*;

  a_status_on_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_OK) |-> run_last)
    else $error("status reported on a non-final transaction");

  a_status_item: assert property (@(posedge clk) disable iff (rst)
    (!empty && !out_valid) |-> (run_last && out_byte == 8'd0 && status != ST_OK))
    else $error("malformed status-only transaction");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not cleared by reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(status)
                          && $stable(run_last) && $stable(out_valid)))
    else $error("waiting result changed");

endmodule

bind plain_lz77_stream_decompressor lzd_checker u_lzd_checker (.*);

/* tb/sv/tb.sv */
// Self-checking bench for the plain LZ77 stream decompressor: builds compressed
// streams, predicts every decompressed byte and status, checks each result in order.
// Depends on lzd_pkg and plain_lz77_stream_decompressor.
`timescale 1ns / 1ps

module tb;
  import lzd_pkg::*;

  localparam int WD_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int WIN = LZD_WINDOW_BYTES;

  typedef enum int unsigned {
    PH_FLAG0, PH_FLAG1, PH_FLAG2, PH_FLAG3, PH_ITEM, PH_TOK_HI, PH_NIB,
    PH_EXT8, PH_EXT16_LO, PH_EXT16_HI, PH_INPUT_DONE
  } parse_phase_e;

  typedef enum int {END_LIMIT, END_BADOFF, END_INPUT, END_TRUNC} ending_e;

  logic        clk = 0;
  logic        rst = 1;
  logic        push = 0;
  logic        full;
  logic        cmd = 0;
  logic [7:0]  in_byte = 0;
  logic        in_last = 0;
  logic        empty;
  logic        pop = 0;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        run_last;
  logic [2:0]  status;
  logic        cfg_wr_en = 0;
  logic [31:0] cfg_wr_data = 0;

  plain_lz77_stream_decompressor u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .cmd(cmd), .in_byte(in_byte),
    .in_last(in_last), .empty(empty), .pop(pop), .out_valid(out_valid),
    .out_byte(out_byte), .run_last(run_last), .status(status),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // decoder shadow state
  bit [7:0]     hist [WIN];
  logic [31:0]  out_limit = 0;
  logic [31:0]  dec_bw = 0;
  logic [31:0]  flag_w = 0;
  logic [5:0]   flags_left = 0;
  parse_phase_e ph = PH_FLAG0;
  logic [15:0]  tok_v = 0;
  logic [12:0]  match_off = 0;
  logic [16:0]  copy_left = 0;
  logic [3:0]   hi_nib = 0;
  bit           nib_pend = 0;
  status_t      dec_fin = ST_OK;

  out_item_t step_q[$];
  out_item_t predicted_out_q[$];
  in_item_t  stream_q[$];
  in_item_t  build_q[$];

  int err_cnt = 0;
  int res_cnt = 0;
  bit idle_en = 1;
  bit hold_req = 0;

  task automatic put_byte(input logic [7:0] b);
    out_item_t r;
    r.out_valid = 1'b1;
    r.out_byte = b;
    r.run_last = 1'b0;
    r.status = ST_OK;
    step_q.push_back(r);
    hist[dec_bw[12:0]] = b;
    dec_bw++;
    if (dec_bw >= out_limit) begin
      dec_fin = ST_LIMIT;
      copy_left = 0;
    end
  endtask

  function automatic parse_phase_e next_elem();
    return (flags_left == 0) ? PH_FLAG0 : PH_ITEM;
  endfunction

  task automatic drain_copy();
    logic [31:0] src;
    while (copy_left > 0 && step_q.size() < LZD_MAX_BURST && dec_fin == ST_OK) begin
      src = dec_bw - {19'd0, match_off} - 32'd1;
      copy_left--;
      put_byte(hist[src[12:0]]);
    end
  endtask

  task automatic start_copy(input logic [16:0] len);
    ph = next_elem();
    if ({19'd0, match_off} + 32'd1 > dec_bw) begin
      dec_fin = ST_BADOFF;
      copy_left = 0;
    end else begin
      copy_left = len;
      drain_copy();
    end
  endtask

  task automatic nibble_len(input logic [3:0] nib);
    if (nib < 15) start_copy(17'(nib) + 17'd10);
    else ph = PH_EXT8;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    case (ph)
      PH_ITEM: begin
        flags_left = flags_left - 6'd1;
        if (!flag_w[flags_left[4:0]]) begin
          put_byte(b);
          ph = next_elem();
        end else begin
          tok_v = {8'd0, b};
          ph = PH_TOK_HI;
        end
      end
      PH_TOK_HI: begin
        tok_v = {b, tok_v[7:0]};
        match_off = tok_v[15:3];
        if (tok_v[2:0] < 3'd7) start_copy(17'(tok_v[2:0]) + 17'd3);
        else if (nib_pend) begin
          nib_pend = 0;
          nibble_len(hi_nib);
        end else ph = PH_NIB;
      end
      PH_NIB: begin
        hi_nib = b[7:4];
        nib_pend = 1;
        nibble_len(b[3:0]);
      end
      PH_EXT8: begin
        if (b < 8'd255) start_copy(17'(b) + 17'd25);
        else ph = PH_EXT16_LO;
      end
      PH_EXT16_LO: begin
        tok_v = {8'd0, b};
        ph = PH_EXT16_HI;
      end
      PH_EXT16_HI: start_copy({1'b0, b, tok_v[7:0]} + 17'd3);
      default: begin
        if (ph > PH_FLAG3) ph = PH_FLAG0;
        flag_w = flag_w | (32'(b) << (8 * ph));
        if (ph == PH_FLAG3) begin
          flags_left = 6'd32;
          ph = PH_ITEM;
        end else ph = parse_phase_e'(ph + 1);
      end
    endcase
  endtask

  task automatic decode_step(input logic c, input logic [7:0] b, input logic l);
    out_item_t r;
    status_t st;
    step_q.delete();
    if (dec_fin == ST_OK && dec_bw >= out_limit) begin
      dec_fin = ST_LIMIT;
      copy_left = 0;
    end else if (dec_fin == ST_OK && c == CMD_CONT) begin
      if (copy_left > 0) begin
        drain_copy();
        if (dec_fin == ST_OK && copy_left == 0 && ph == PH_INPUT_DONE) dec_fin = ST_END;
      end
    end else if (dec_fin == ST_OK && copy_left == 0) begin
      if (ph == PH_FLAG0 && flags_left == 0) flag_w = 0;
      parse_byte(b);
      if (dec_fin == ST_OK && l) begin
        if (copy_left > 0) ph = PH_INPUT_DONE;
        else if (ph == PH_FLAG0 || ph == PH_ITEM) dec_fin = ST_END;
        else dec_fin = ST_TRUNC;
      end
    end
    if (dec_fin != ST_OK) st = dec_fin;
    else if (copy_left > 0) st = ST_PENDING;
    else st = ST_OK;
    if (step_q.size() == 0) begin
      if (st == ST_OK) return;
      r.out_valid = 1'b0;
      r.out_byte = 8'd0;
      r.run_last = 1'b0;
      r.status = ST_OK;
      step_q.push_back(r);
    end
    step_q[step_q.size() - 1].run_last = 1'b1;
    step_q[step_q.size() - 1].status = st;
    foreach (step_q[i]) predicted_out_q.push_back(step_q[i]);
  endtask

  // stream builder
  longint unsigned gen_bw = 0;
  bit              gen_npend = 0;
  logic [3:0]      gen_hi = 0;
  bit              dir_mode = 0;

  task automatic add_item(input logic c, input logic [7:0] b, input logic l);
    in_item_t it;
    it.cmd = c;
    it.in_byte = b;
    it.in_last = l;
    build_q.push_back(it);
  endtask

  task automatic add_match(input int unsigned off, input int unsigned len, input bit f16,
                           input bit last);
    logic [15:0] tok;
    logic [3:0]  nib;
    logic [3:0]  hi;
    int unsigned rem;
    bit          code7;
    bit          first;
    code7 = f16 || len >= 10;
    tok = {off[12:0], code7 ? 3'd7 : 3'(len - 3)};
    add_item(CMD_PUSH, tok[7:0], 0);
    add_item(CMD_PUSH, tok[15:8], 0);
    if (code7) begin
      if (gen_npend) begin
        nib = gen_hi;
        gen_npend = 0;
      end else begin
        nib = (f16 || len >= 25) ? 4'd15 : 4'(len - 10);
        hi = 4'($urandom);
        add_item(CMD_PUSH, {hi, nib}, 0);
        gen_hi = hi;
        gen_npend = 1;
      end
      if (nib < 15) len = nib + 10;
      else begin
        if (len < 25 && !f16) len = 25 + $urandom_range(0, 30);
        if (!f16 && len < 280) add_item(CMD_PUSH, 8'(len - 25), 0);
        else begin
          add_item(CMD_PUSH, 8'hFF, 0);
          add_item(CMD_PUSH, 8'(len - 3), 0);
          add_item(CMD_PUSH, 8'((len - 3) >> 8), 0);
        end
      end
    end
    build_q[build_q.size() - 1].in_last = last;
    gen_bw += len;
    rem = (len > 64) ? len - 64 : 0;
    first = 1;
    while (rem > 0) begin
      if ((dir_mode && first) || $urandom_range(0, 5) == 0)
        add_item(CMD_PUSH, 8'($urandom), 1'($urandom));
      add_item(CMD_CONT, 8'($urandom), 1'($urandom));
      rem -= (rem > 64) ? 64 : rem;
      first = 0;
    end
  endtask

  task automatic add_group(input int n, input bit last_on_final);
    logic [31:0] fw;
    int          base;
    bit          m;
    bit          f16;
    bit          l;
    int unsigned lim;
    int unsigned off;
    int unsigned len;
    int unsigned r;
    logic [7:0]  lit;
    base = build_q.size();
    fw = $urandom;
    repeat (4) add_item(CMD_PUSH, 8'd0, 0);
    for (int i = 0; i < n; i++) begin
      l = last_on_final && (i == n - 1);
      m = (gen_bw > 0) && $urandom_range(0, 1);
      lim = (gen_bw > WIN) ? WIN : int'(gen_bw);
      if (lim == 0) lim = 1;
      off = ($urandom_range(0, 9) == 0) ? lim - 1 :
            $urandom_range(0, (lim > 40) ? 39 : lim - 1);
      r = $urandom_range(0, 99);
      len = (r < 50) ? $urandom_range(3, 9) : (r < 80) ? $urandom_range(10, 24) :
            (r < 95) ? $urandom_range(25, 279) : $urandom_range(280, 1200);
      f16 = (r >= 95) || ($urandom_range(0, 29) == 0);
      lit = 8'($urandom);
      if (dir_mode && i < 10) begin
        m = 1;
        f16 = 0;
        case (i)
          0: begin m = 0; lit = 8'h00; end
          1: begin m = 0; lit = 8'hFF; end
          2: begin off = 0; len = 3; end
          3: begin off = 1; len = 9; end
          4: begin off = 0; len = 10; end
          5: begin off = 1; len = 24; end
          6: begin off = 0; len = 25; end
          7: begin off = 4; len = 279; end
          8: begin off = 0; len = 280; end
          default: begin off = 0; len = 3; f16 = 1; end
        endcase
      end
      fw[31 - i] = m;
      if (m) add_match(off, len, f16, l);
      else begin
        add_item(CMD_PUSH, lit, l);
        gen_bw++;
        if (!l && (($urandom_range(0, 14) == 0) || (dir_mode && i == 1)))
          add_item(CMD_CONT, 8'($urandom), 1'($urandom));
      end
    end
    for (int k = 0; k < 4; k++) build_q[base + k].in_byte = fw[8 * k +: 8];
  endtask

  task automatic release_build();
    foreach (build_q[i]) stream_q.push_back(build_q[i]);
    build_q.delete();
  endtask

  task automatic wait_idle();
    while (!(stream_q.size() == 0 && !push && predicted_out_q.size() == 0))
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_limit(input logic [31:0] v);
    wait_idle();
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    out_limit = v;
    cfg_wr_en <= 0;
    @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH result %0d %s: got %0h want %0h", res_cnt, what, got, want);
    err_cnt++;
  endtask

  // driver
  int  tx_gap = 0;
  bit  tx_calm = 0;
  always @(posedge clk) begin
    in_item_t it;
    bit fire;
    fire = push && !full;
    if (rst) begin
      push <= 0;
    end else begin
      if (fire) decode_step(cmd, in_byte, in_last);
      if (fire && $urandom_range(0, 39) == 0) tx_calm = !tx_calm;
      if (!push || fire) begin
        if (tx_gap > 0) begin
          tx_gap--;
          push <= 0;
        end else if (stream_q.size() > 0) begin
          it = stream_q.pop_front();
          push <= 1;
          cmd <= it.cmd;
          in_byte <= it.in_byte;
          in_last <= it.in_last;
          if (idle_en && !tx_calm && $urandom_range(0, 5) == 0)
            tx_gap = $urandom_range(1, 10);
        end else begin
          push <= 0;
        end
      end
    end
  end

  // monitor
  int rx_gap = 0;
  int hold_cnt = 0;
  bit rx_calm = 0;
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      pop <= 0;
    end else begin
      if (pop && !empty) begin
        if (predicted_out_q.size() == 0) begin
          report_mismatch("unexpected transaction",
                          32'({out_valid, out_byte, run_last, status}), 32'd0);
        end else begin
          want = predicted_out_q.pop_front();
          if (out_valid !== want.out_valid)
            report_mismatch("out_valid", 32'(out_valid), 32'(want.out_valid));
          if (out_byte !== want.out_byte)
            report_mismatch("out_byte", 32'(out_byte), 32'(want.out_byte));
          if (run_last !== want.run_last)
            report_mismatch("run_last", 32'(run_last), 32'(want.run_last));
          if (status !== want.status)
            report_mismatch("status", 32'(status), 32'(want.status));
        end
        res_cnt++;
        if ($urandom_range(0, 59) == 0) rx_calm = !rx_calm;
      end
      if (hold_req) begin
        hold_req = 0;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        pop <= 0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        pop <= 0;
      end else begin
        pop <= 1;
        if (idle_en && !rx_calm && $urandom_range(0, 7) == 0) rx_gap = $urandom_range(1, 10);
      end
    end
  end

  // watchdog
  int stuck_cycles = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= WD_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    ending_e     kind;
    logic [31:0] fw;
    int unsigned off;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    set_limit(32'hFFFF_FFFF);
    dir_mode = 1;
    add_group(32, 0);
    dir_mode = 0;
    release_build();

    set_limit(32'h0040_0000 + $urandom_range(0, 4095));
    for (int g = 0; g < 4; g++) begin
      add_group(32, 0);
    end
    release_build();
    hold_req = 1;

    wait_idle();
    idle_en = 0;
    kind = ending_e'($urandom_range(0, 3));
    if (kind == END_BADOFF && gen_bw >= WIN) kind = END_INPUT;
    case (kind)
      END_LIMIT: begin
        set_limit(dec_bw + $urandom_range(0, 60));
        add_group(32, 0);
        add_group(32, 0);
      end
      END_BADOFF: begin
        fw = $urandom | 32'h8000_0000;
        for (int k = 0; k < 4; k++) add_item(CMD_PUSH, fw[8 * k +: 8], 0);
        off = $urandom_range(int'(gen_bw), WIN - 1);
        add_item(CMD_PUSH, {off[4:0], 3'($urandom_range(0, 6))}, 0);
        add_item(CMD_PUSH, off[12:5], 0);
      end
      END_INPUT: add_group($urandom_range(1, 6), 1);
      default: begin
        fw = $urandom | 32'h8000_0000;
        for (int k = 0; k < 4; k++) add_item(CMD_PUSH, fw[8 * k +: 8], 0);
        add_item(CMD_PUSH, 8'($urandom), 1);
      end
    endcase
    release_build();

    set_limit(32'd0);
    add_item(CMD_PUSH, 8'($urandom), 1);
    add_item(CMD_CONT, 8'($urandom), 0);
    add_item(CMD_PUSH, 8'($urandom), 0);
    release_build();
    wait_idle();
    repeat (50) @(posedge clk);

    if (err_cnt == 0 && predicted_out_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/lzd_pkg.sv
rtl/core/lzd_front.sv
rtl/core/lzd_out_q.sv
rtl/core/lzd_back.sv
rtl/core/plain_lz77_stream_decompressor.sv
rtl/core/lzd_checker.sv
tb/sv/tb.sv
